/* rtl/assert_macros.svh */
// Assertion macros shared by the onset detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FEDO_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FEDO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FEDO_ASSERT(lbl, clk, rstn, prop, msg)
`define FEDO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/fedo_pkg.sv */
// Shared widths, constants and types of the frame energy onset detector.
`default_nettype none
package fedo_pkg;
    localparam int BAND_W             = 16;
    localparam int ACC_W              = 21;
    localparam int GAIN_W             = 10;
    localparam int SLOT_W             = 5;
    localparam int GAIN_FRAC          = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd448;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 21'sh0FFFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 21'sh100000;
    localparam int SHORT_WINDOW_DEF   = 5;
    localparam int LONG_WINDOW_DEF    = 50;
    localparam int BATCH_FRAMES_DEF   = 20;

    typedef struct packed {
        logic                    shift;
        logic signed [ACC_W-1:0] energy;
    } t_win_in;
endpackage
`default_nettype wire

/* rtl/fedo_cell.sv */
// One storage cell of the frame energy delay line.
`default_nettype none
module fedo_cell
    import fedo_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic signed [ACC_W-1:0] i_d,
    output logic signed [ACC_W-1:0]      o_q
);
    logic signed [ACC_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

/* rtl/fedo_window.sv */
// Sliding window sum over a chain of frame energy cells.
`default_nettype none
module fedo_window
    import fedo_pkg::*;
#(
    parameter int DEPTH = SHORT_WINDOW_DEF,
    localparam int SUM_W = ACC_W + $clog2(DEPTH)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_win_in                 i_win,
    output logic signed [SUM_W-1:0]      o_sum
);
    logic signed [ACC_W-1:0] w_q [DEPTH];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            fedo_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (i_win.shift),
                .i_d    (i_win.energy),
                .o_q    (w_q[k])
            );
        end else begin : g_body
            fedo_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (i_win.shift),
                .i_d    (w_q[k-1]),
                .o_q    (w_q[k])
            );
        end
    end

    always_comb begin
        n_sum = r_sum + SUM_W'(i_win.energy) - SUM_W'(w_q[DEPTH-1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_win.shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
endmodule
`default_nettype wire

/* rtl/frame_energy_onset_detector_unit.sv */
// Top level of the frame energy onset detector: band accumulator, windows, level test.
//
//  channel | direction | handshake           | payload
//  band in | input     | i_valid / o_stall   | i_band_value, i_last_band
//  result  | output    | o_valid / i_stall   | o_frame_energy .. o_frame_slot
//  config  | input     | i_cfg_we            | i_cfg_wdata (gain, Q2.8)
//
// One band request per cycle while o_stall is low; a band without the last-band mark yields no result.
// A closed frame reaches the output register after its last band through the accumulate,
// window update, multiply and compare stages.
// Reset is synchronous and clears the accumulator, frame counter, both delay lines, sums, detect flag and valid bits.
// A stalled output holds its request; the stages behind it fill before o_stall rises.
`default_nettype none
`include "assert_macros.svh"
module frame_energy_onset_detector_unit
    import fedo_pkg::*;
#(
    parameter int SHORT_WINDOW = SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = LONG_WINDOW_DEF,
    parameter int BATCH_FRAMES = BATCH_FRAMES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [GAIN_W-1:0]        i_cfg_wdata,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [BAND_W-1:0] i_band_value,
    input  wire logic                     i_last_band,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic signed [ACC_W-1:0]       o_frame_energy,
    output logic                          o_above_now,
    output logic                          o_detected,
    output logic                          o_batch_end,
    output logic                          o_send_batch,
    output logic [SLOT_W-1:0]             o_frame_slot
);
    localparam int SS_W   = ACC_W + $clog2(SHORT_WINDOW);
    localparam int LS_W   = ACC_W + $clog2(LONG_WINDOW);
    localparam int FC_W   = (BATCH_FRAMES > 1) ? $clog2(BATCH_FRAMES) : 1;
    localparam int LK_W   = $clog2(LONG_WINDOW + 1);
    localparam int GK_W   = GAIN_W + $clog2(SHORT_WINDOW + 1);
    localparam int LP_W   = SS_W + LK_W + 1;
    localparam int RP_W   = LS_W + GK_W + 1;
    localparam int LH_W   = LP_W + GAIN_FRAC;
    localparam int CMP_W  = ((LH_W > RP_W) ? LH_W : RP_W) + 1;

    logic [GAIN_W-1:0]       r_gain;
    logic signed [ACC_W-1:0] r_acc;
    logic [FC_W-1:0]         r_fcnt;
    logic                    r_detect;

    logic                    r_v1, r_v2, r_v3, r_o_valid;
    logic signed [ACC_W-1:0] r_s1_energy, r_s2_energy, r_s3_energy, r_o_energy;
    logic [FC_W-1:0]         r_s1_slot, r_s2_slot, r_s3_slot, r_o_slot;
    logic                    r_s1_bend, r_s2_bend, r_s3_bend, r_o_bend;
    logic signed [LP_W-1:0]  r_s3_lhs;
    logic signed [RP_W-1:0]  r_s3_rhs;
    logic                    r_o_above, r_o_detected;

    logic                    rdy1, rdy2, rdy3, rdy4, in_acc, frame_close;
    logic signed [ACC_W:0]   n_wide;
    logic signed [ACC_W-1:0] n_energy;
    logic                    n_bend;
    logic [GK_W-1:0]         n_gk;
    logic signed [LP_W-1:0]  n_lhs;
    logic signed [RP_W-1:0]  n_rhs;
    logic signed [LH_W-1:0]  n_lhs_sh;
    logic signed [CMP_W-1:0] n_lhs_cmp, n_rhs_cmp;
    logic                    n_above;
    logic signed [SS_W-1:0]  w_short_sum;
    logic signed [LS_W-1:0]  w_long_sum;
    t_win_in                 w_win;

    assign rdy4        = !r_o_valid || !i_stall;
    assign rdy3        = !r_v3 || rdy4;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign o_stall     = !rdy1;
    assign in_acc      = i_valid && rdy1;
    assign frame_close = in_acc && i_last_band;

    always_comb begin
        n_wide = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(i_band_value);
        if (n_wide[ACC_W] != n_wide[ACC_W-1]) begin
            n_energy = n_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_energy = n_wide[ACC_W-1:0];
        end
        n_bend    = (r_fcnt == FC_W'(BATCH_FRAMES - 1));
        n_gk      = GK_W'(r_gain) * GK_W'(SHORT_WINDOW);
        n_lhs     = $signed(w_short_sum) * $signed({1'b0, LK_W'(LONG_WINDOW)});
        n_rhs     = $signed(w_long_sum) * $signed({1'b0, n_gk});
        n_lhs_sh  = {r_s3_lhs, {GAIN_FRAC{1'b0}}};
        n_lhs_cmp = CMP_W'(n_lhs_sh);
        n_rhs_cmp = CMP_W'(r_s3_rhs);
        n_above   = (n_lhs_cmp > n_rhs_cmp);
    end

    assign w_win.shift  = r_v1 && rdy2;
    assign w_win.energy = r_s1_energy;

    fedo_window #(.DEPTH(SHORT_WINDOW)) u_short (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_win  (w_win),
        .o_sum  (w_short_sum)
    );

    fedo_window #(.DEPTH(LONG_WINDOW)) u_long (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_win  (w_win),
        .o_sum  (w_long_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_RESET;
            r_acc     <= '0;
            r_fcnt    <= '0;
            r_detect  <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_acc <= i_last_band ? '0 : n_energy;
            end
            if (frame_close) begin
                r_fcnt <= n_bend ? '0 : r_fcnt + 1'b1;
            end
            if (rdy1) begin
                r_v1 <= frame_close;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_o_valid <= r_v3;
            end
            if (r_v3 && rdy4 && n_above) begin
                r_detect <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_energy <= n_energy;
            r_s1_slot   <= r_fcnt;
            r_s1_bend   <= n_bend;
        end
        if (rdy2) begin
            r_s2_energy <= r_s1_energy;
            r_s2_slot   <= r_s1_slot;
            r_s2_bend   <= r_s1_bend;
        end
        if (rdy3) begin
            r_s3_energy <= r_s2_energy;
            r_s3_slot   <= r_s2_slot;
            r_s3_bend   <= r_s2_bend;
            r_s3_lhs    <= n_lhs;
            r_s3_rhs    <= n_rhs;
        end
        if (rdy4) begin
            r_o_energy   <= r_s3_energy;
            r_o_slot     <= r_s3_slot;
            r_o_bend     <= r_s3_bend;
            r_o_above    <= n_above;
            r_o_detected <= r_detect || n_above;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_frame_energy = r_o_energy;
    assign o_above_now    = r_o_above;
    assign o_detected     = r_o_detected;
    assign o_batch_end    = r_o_bend;
    assign o_send_batch   = r_o_bend && r_o_detected;
    assign o_frame_slot   = SLOT_W'(r_o_slot);

    `FEDO_ASSERT(a_detect_sticky, i_clk, i_rst_n, r_detect |=> r_detect, "detect flag dropped")
    `FEDO_ASSERT(a_above_sets_detect, i_clk, i_rst_n, (o_valid && o_above_now) |-> o_detected, "above without detect")
    `FEDO_ASSERT(a_batch_slot, i_clk, i_rst_n, (o_valid && o_batch_end) |-> (r_o_slot == FC_W'(BATCH_FRAMES - 1)), "batch end at wrong slot")
    `FEDO_ASSERT(a_acc_cleared, i_clk, i_rst_n, frame_close |=> (r_acc == '0), "accumulator not cleared at frame end")
endmodule
`default_nettype wire
